// ===== hdl/corexy_bresenham_step_generator_top_defines.svh =====
// Assertion macros shared by the step generator RTL.
`ifndef COREXY_BRESENHAM_STEP_GENERATOR_TOP_DEFINES_SVH
`define COREXY_BRESENHAM_STEP_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition violated");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check violated");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/cbsg_pkg.sv =====
// Types and constants for the CoreXY Bresenham step generator.
package cbsg_pkg;

  localparam int SPM_W  = 12;
  localparam int TGT_W  = 20;
  localparam int POS_W  = 24;
  localparam int MPOS_W = 32;
  localparam int CNT_W  = 26;
  localparam int ERR_W  = 27;
  localparam int PROD_W = 32;

  localparam logic [SPM_W-1:0] SPM_RESET = 12'd80;

  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Request after coordinate conversion, as held in the queue
  typedef struct packed {
    logic                    req_type;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
  } cbsg_cmd_t;

  // Q8 product to steps, rounded half away from zero
  function automatic logic signed [POS_W-1:0] q8_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + (p[PROD_W-1] ? 32'sd127 : 32'sd128);
    return $signed(s[PROD_W-1:8]);
  endfunction

endpackage

// ===== hdl/cbsg_ifs.sv =====
// Request and result channel interfaces.
interface cbsg_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [19:0] target_x;
  logic signed [19:0] target_y;

  modport source (output valid, output req_type, output target_x, output target_y,
                  input ready);
  modport sink   (input valid, input req_type, input target_x, input target_y,
                  output ready);
endinterface

interface cbsg_out_if;
  logic               valid;
  logic               ready;
  logic               step_pulse_a;
  logic               step_pulse_b;
  logic               dir_out_a;
  logic               dir_out_b;
  logic               moving;
  logic               rejected;
  logic signed [23:0] pos_x_steps;
  logic signed [23:0] pos_y_steps;
  logic signed [31:0] pos_a_steps;
  logic signed [31:0] pos_b_steps;

  modport source (output valid, output step_pulse_a, output step_pulse_b,
                  output dir_out_a, output dir_out_b, output moving, output rejected,
                  output pos_x_steps, output pos_y_steps, output pos_a_steps,
                  output pos_b_steps, input ready);
  modport sink   (input valid, input step_pulse_a, input step_pulse_b,
                  input dir_out_a, input dir_out_b, input moving, input rejected,
                  input pos_x_steps, input pos_y_steps, input pos_a_steps,
                  input pos_b_steps, output ready);
endinterface

// ===== hdl/corexy_bresenham_step_generator_top.sv =====
// Top level of the CoreXY Bresenham step generator.
//
//   channel   direction  handshake      content
//   in_req    in         valid/ready    req_type, target_x, target_y
//   out_res   out        valid/ready    pulses, directions, moving, rejected, positions
//   cfg       in         cfg_we         steps_per_mm_q4
//
// One request per clock sustained while out_res is ready; a request's result passes
// through the product register, a queue slot and the result register.
// The step engine does each move setup and each tick iteration as one state update.
// Reset is synchronous on rst_n; there is no clearing pass.
// A stalled out_res fills the queue and then drops in_req.ready.
module corexy_bresenham_step_generator_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [cbsg_pkg::SPM_W-1:0] cfg_wdata,
  cbsg_in_if.sink                    in_req,
  cbsg_out_if.source                 out_res
);
  import cbsg_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  cbsg_cmd_t push_data, pop_data;

  cbsg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cbsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cbsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_res   (out_res)
  );

endmodule

// ===== hdl/cbsg_front.sv =====
// Front end: accepts requests, scales targets to steps, pushes into the queue.
module cbsg_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cbsg_pkg::SPM_W-1:0]      cfg_wdata,
  cbsg_in_if.sink                         in_req,
  output logic                            push_valid,
  input  logic                            push_ready,
  output cbsg_pkg::cbsg_cmd_t             push_data
);
  import cbsg_pkg::*;

  logic [SPM_W-1:0]         spm_r;
  logic                     fv_r;
  logic                     ftype_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [PROD_W:0]   mul_x, mul_y;
  logic                     take;

  assign in_req.ready = !fv_r || push_ready;
  assign take         = in_req.valid && in_req.ready;

  assign mul_x = in_req.target_x * $signed({1'b0, spm_r});
  assign mul_y = in_req.target_y * $signed({1'b0, spm_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r <= SPM_RESET;
      fv_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        spm_r <= cfg_wdata;
      end
      if (in_req.ready) begin
        fv_r <= in_req.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ftype_r  <= in_req.req_type;
      prod_x_r <= mul_x[PROD_W-1:0];
      prod_y_r <= mul_y[PROD_W-1:0];
    end
  end

  assign push_valid         = fv_r;
  assign push_data.req_type = ftype_r;
  assign push_data.tx       = q8_round(prod_x_r);
  assign push_data.ty       = q8_round(prod_y_r);

endmodule

// ===== hdl/cbsg_queue.sv =====
// Short request queue between the front end and the step engine.
`include "corexy_bresenham_step_generator_top_defines.svh"
module cbsg_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  cbsg_pkg::cbsg_cmd_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cbsg_pkg::cbsg_cmd_t pop_data
);
  import cbsg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cbsg_cmd_t       slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_ALWAYS(count_in_range, count_r <= CW'(DEPTH))
  `ASSERT_ALWAYS(empty_ptrs_match, count_r != '0 || rd_ptr_r == wr_ptr_r)

endmodule

// ===== hdl/cbsg_back.sv =====
// Step engine: move setup with CoreXY mixing, one Bresenham iteration per tick.
`include "corexy_bresenham_step_generator_top_defines.svh"
module cbsg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  cbsg_pkg::cbsg_cmd_t pop_data,
  cbsg_out_if.source          out_res
);
  import cbsg_pkg::*;

  logic                     out_valid_r;
  logic                     pulse_a_r, pulse_b_r, rej_r;
  logic                     pulse_a_nxt, pulse_b_nxt, rej_nxt;
  logic signed [POS_W-1:0]  x_pos_r, y_pos_r, x_pos_nxt, y_pos_nxt;
  logic [MPOS_W-1:0]        a_pos_r, b_pos_r, a_pos_nxt, b_pos_nxt;
  logic [CNT_W-1:0]         cnt_a_r, cnt_b_r, cnt_a_nxt, cnt_b_nxt;
  logic [CNT_W-1:0]         gap_a_r, gap_b_r, gap_a_nxt, gap_b_nxt;
  logic [CNT_W-1:0]         rem_r, rem_a_r, rem_b_r, rem_nxt, rem_a_nxt, rem_b_nxt;
  logic signed [ERR_W-1:0]  err_a_r, err_b_r, err_a_nxt, err_b_nxt;
  logic                     dir_a_r, dir_b_r, dir_a_nxt, dir_b_nxt;
  logic                     fire, busy;

  logic signed [POS_W:0]    dx, dy;
  logic signed [CNT_W-1:0]  da, db;
  logic [CNT_W-1:0]         abs_a, abs_b, longest;
  logic signed [ERR_W-1:0]  ea_dec, eb_dec, ea_inc, eb_inc;
  logic                     step_a, step_b;

  assign pop_ready = !out_valid_r || out_res.ready;
  assign fire      = pop_valid && pop_ready;
  assign busy      = rem_r != '0;

  always_comb begin
    dx      = {pop_data.tx[POS_W-1], pop_data.tx} - {x_pos_r[POS_W-1], x_pos_r};
    dy      = {pop_data.ty[POS_W-1], pop_data.ty} - {y_pos_r[POS_W-1], y_pos_r};
    da      = {dx[POS_W], dx} + {dy[POS_W], dy};
    db      = {dx[POS_W], dx} - {dy[POS_W], dy};
    abs_a   = da[CNT_W-1] ? CNT_W'(-da) : CNT_W'(da);
    abs_b   = db[CNT_W-1] ? CNT_W'(-db) : CNT_W'(db);
    longest = (abs_a > abs_b) ? abs_a : abs_b;

    // Both candidate errors; the step decision picks one
    ea_dec = err_a_r - $signed({1'b0, cnt_a_r});
    eb_dec = err_b_r - $signed({1'b0, cnt_b_r});
    ea_inc = err_a_r + $signed({1'b0, gap_a_r});
    eb_inc = err_b_r + $signed({1'b0, gap_b_r});
    step_a = ea_dec[ERR_W-1] && (rem_a_r != '0);
    step_b = eb_dec[ERR_W-1] && (rem_b_r != '0);
  end

  always_comb begin
    x_pos_nxt   = x_pos_r;
    y_pos_nxt   = y_pos_r;
    a_pos_nxt   = a_pos_r;
    b_pos_nxt   = b_pos_r;
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    gap_a_nxt   = gap_a_r;
    gap_b_nxt   = gap_b_r;
    rem_nxt     = rem_r;
    rem_a_nxt   = rem_a_r;
    rem_b_nxt   = rem_b_r;
    err_a_nxt   = err_a_r;
    err_b_nxt   = err_b_r;
    dir_a_nxt   = dir_a_r;
    dir_b_nxt   = dir_b_r;
    pulse_a_nxt = 1'b0;
    pulse_b_nxt = 1'b0;
    rej_nxt     = 1'b0;
    if (pop_data.req_type == REQ_MOVE) begin
      if (busy) begin
        rej_nxt = 1'b1;
      end else begin
        x_pos_nxt = pop_data.tx;
        y_pos_nxt = pop_data.ty;
        dir_a_nxt = !da[CNT_W-1];
        dir_b_nxt = !db[CNT_W-1];
        cnt_a_nxt = abs_a;
        cnt_b_nxt = abs_b;
        gap_a_nxt = longest - abs_a;
        gap_b_nxt = longest - abs_b;
        rem_nxt   = longest;
        rem_a_nxt = abs_a;
        rem_b_nxt = abs_b;
        err_a_nxt = $signed({2'b00, longest[CNT_W-1:1]});
        err_b_nxt = $signed({2'b00, longest[CNT_W-1:1]});
      end
    end else if (busy) begin
      rem_nxt     = rem_r - 1'b1;
      pulse_a_nxt = step_a;
      pulse_b_nxt = step_b;
      err_a_nxt   = step_a ? ea_inc : ea_dec;
      err_b_nxt   = step_b ? eb_inc : eb_dec;
      if (step_a) begin
        rem_a_nxt = rem_a_r - 1'b1;
        a_pos_nxt = a_pos_r + (dir_a_r ? 32'd1 : '1);
      end
      if (step_b) begin
        rem_b_nxt = rem_b_r - 1'b1;
        b_pos_nxt = b_pos_r + (dir_b_r ? 32'd1 : '1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pulse_a_r   <= 1'b0;
      pulse_b_r   <= 1'b0;
      rej_r       <= 1'b0;
      x_pos_r     <= '0;
      y_pos_r     <= '0;
      a_pos_r     <= '0;
      b_pos_r     <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      gap_a_r     <= '0;
      gap_b_r     <= '0;
      rem_r       <= '0;
      rem_a_r     <= '0;
      rem_b_r     <= '0;
      err_a_r     <= '0;
      err_b_r     <= '0;
      dir_a_r     <= 1'b0;
      dir_b_r     <= 1'b0;
    end else begin
      if (pop_ready) begin
        out_valid_r <= pop_valid;
      end
      if (fire) begin
        pulse_a_r <= pulse_a_nxt;
        pulse_b_r <= pulse_b_nxt;
        rej_r     <= rej_nxt;
        x_pos_r   <= x_pos_nxt;
        y_pos_r   <= y_pos_nxt;
        a_pos_r   <= a_pos_nxt;
        b_pos_r   <= b_pos_nxt;
        cnt_a_r   <= cnt_a_nxt;
        cnt_b_r   <= cnt_b_nxt;
        gap_a_r   <= gap_a_nxt;
        gap_b_r   <= gap_b_nxt;
        rem_r     <= rem_nxt;
        rem_a_r   <= rem_a_nxt;
        rem_b_r   <= rem_b_nxt;
        err_a_r   <= err_a_nxt;
        err_b_r   <= err_b_nxt;
        dir_a_r   <= dir_a_nxt;
        dir_b_r   <= dir_b_nxt;
      end
    end
  end

  // The result reflects state after the request, so state registers drive it directly
  assign out_res.valid        = out_valid_r;
  assign out_res.step_pulse_a = pulse_a_r;
  assign out_res.step_pulse_b = pulse_b_r;
  assign out_res.dir_out_a    = dir_a_r;
  assign out_res.dir_out_b    = dir_b_r;
  assign out_res.moving       = busy;
  assign out_res.rejected     = rej_r;
  assign out_res.pos_x_steps  = x_pos_r;
  assign out_res.pos_y_steps  = y_pos_r;
  assign out_res.pos_a_steps  = $signed(a_pos_r);
  assign out_res.pos_b_steps  = $signed(b_pos_r);

  `ASSERT_NEXT(idle_tick_no_pulse, fire && pop_data.req_type == REQ_TICK && !busy, !pulse_a_r && !pulse_b_r)
  `ASSERT_ALWAYS(steps_left_bounded, rem_a_r <= cnt_a_r && rem_b_r <= cnt_b_r)

endmodule
